>>> src/mid_pkg.sv
// ----------------------------------------------------------------------------
// mid_pkg
// Item types, format and row codes, and the mnemonic match tables of the
// MIPS instruction decoder.
// ----------------------------------------------------------------------------
package mid_pkg;

    localparam logic [5:0] ROW_NOOP    = 6'd62;
    localparam logic [5:0] ROW_UNKNOWN = 6'd63;

    localparam logic [1:0] FMT_R    = 2'd0;
    localparam logic [1:0] FMT_I    = 2'd1;
    localparam logic [1:0] FMT_J    = 2'd2;
    localparam logic [1:0] FMT_NONE = 2'd3;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;

    typedef struct packed {
        logic [31:0] instr_word;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  code_index;
        logic [1:0]  insn_format;
        logic [4:0]  src_reg;
        logic [4:0]  tgt_reg;
        logic [4:0]  dst_reg;
        logic [4:0]  shift_amount;
        logic [5:0]  function_code;
        logic [15:0] immediate;
        logic [25:0] jump_field;
        logic [31:0] word_address;
        logic [31:0] branch_target;
    } t_out_item;

    typedef struct packed {
        logic [31:0] base_address;
    } t_cfg_item;

    // opcode 0: row by funct
    function automatic logic [5:0] f_special_row(input logic [5:0] fn);
        logic [5:0] r;
        case (fn)
            6'h20:   r = 6'd0;
            6'h21:   r = 6'd1;
            6'h22:   r = 6'd4;
            6'h23:   r = 6'd5;
            6'h18:   r = 6'd6;
            6'h19:   r = 6'd7;
            6'h1A:   r = 6'd8;
            6'h1B:   r = 6'd9;
            6'h11:   r = 6'd10;
            6'h13:   r = 6'd11;
            6'h10:   r = 6'd12;
            6'h12:   r = 6'd13;
            6'h24:   r = 6'd14;
            6'h25:   r = 6'd16;
            6'h26:   r = 6'd18;
            6'h27:   r = 6'd20;
            6'h00:   r = 6'd21;
            6'h04:   r = 6'd22;
            6'h02:   r = 6'd23;
            6'h06:   r = 6'd24;
            6'h03:   r = 6'd25;
            6'h07:   r = 6'd26;
            6'h2A:   r = 6'd48;
            6'h2B:   r = 6'd49;
            6'h08:   r = 6'd53;
            6'h09:   r = 6'd55;
            6'h0C:   r = 6'd60;
            6'h0D:   r = 6'd61;
            default: r = ROW_UNKNOWN;
        endcase
        return r;
    endfunction

    // opcode 1: row by rt
    function automatic logic [5:0] f_regimm_row(input logic [4:0] rt);
        logic [5:0] r;
        case (rt)
            5'h01:   r = 6'd42;
            5'h11:   r = 6'd44;
            5'h00:   r = 6'd46;
            5'h10:   r = 6'd47;
            default: r = ROW_UNKNOWN;
        endcase
        return r;
    endfunction

    // other opcodes: row by opcode
    function automatic logic [5:0] f_opcode_row(input logic [5:0] op);
        logic [5:0] r;
        case (op)
            6'h08:   r = 6'd2;
            6'h09:   r = 6'd3;
            6'h0C:   r = 6'd15;
            6'h0D:   r = 6'd17;
            6'h0E:   r = 6'd19;
            6'h0F:   r = 6'd27;
            6'h20:   r = 6'd28;
            6'h24:   r = 6'd29;
            6'h21:   r = 6'd30;
            6'h25:   r = 6'd31;
            6'h23:   r = 6'd32;
            6'h22:   r = 6'd33;
            6'h26:   r = 6'd34;
            6'h28:   r = 6'd35;
            6'h29:   r = 6'd36;
            6'h2B:   r = 6'd37;
            6'h2D:   r = 6'd38;
            6'h2E:   r = 6'd39;
            6'h04:   r = 6'd40;
            6'h05:   r = 6'd41;
            6'h07:   r = 6'd43;
            6'h06:   r = 6'd45;
            6'h0A:   r = 6'd50;
            6'h0B:   r = 6'd51;
            6'h02:   r = 6'd52;
            6'h03:   r = 6'd54;
            6'h12:   r = 6'd56;
            6'h2A:   r = 6'd57;
            6'h32:   r = 6'd58;
            6'h3A:   r = 6'd59;
            default: r = ROW_UNKNOWN;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] f_row_format(input logic [5:0] row);
        logic [1:0] f;
        case (row) inside
            6'd2, 6'd3, 6'd15, 6'd17, 6'd19, [6'd27:6'd47], 6'd50, 6'd51,
            [6'd56:6'd59]:    f = FMT_I;
            6'd52, 6'd54:     f = FMT_J;
            ROW_NOOP,
            ROW_UNKNOWN:      f = FMT_NONE;
            default:          f = FMT_R;
        endcase
        return f;
    endfunction

endpackage

>>> src/mid_stream_if.sv
// ----------------------------------------------------------------------------
// mid_stream_if
// Valid/ready channel carrying one payload item of type T.
// ----------------------------------------------------------------------------
interface mid_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/mips_instruction_decoder_top.sv
// ----------------------------------------------------------------------------
// mips_instruction_decoder_top
// Decodes a stream of 32-bit MIPS-I words into table row, format, fields,
// word address and branch target.
// ----------------------------------------------------------------------------
// Throughput is one item per cycle while o_out.ready holds; an accepted item
// passes through the word and address register, then is decoded into the
// result register.
// The word address is formed at acceptance from base_address and the word
// offset counter, which restarts after an item marked last_word. Input ready
// follows o_out.ready combinationally through the two register stages.
// base_address is written over i_cfg, which is always ready.
module mips_instruction_decoder_top
    import mid_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    mid_stream_if.sink          i_cfg,
    mid_stream_if.sink          i_in,
    mid_stream_if.source        o_out
);

    logic [31:0] r_base;
    logic [29:0] r_offset;
    logic [29:0] n_offset;

    logic        r_s1_valid;
    logic [31:0] r_word;
    logic [31:0] r_addr;

    logic        r_s2_valid;
    t_out_item   r_out;
    t_out_item   n_out;

    logic        in_fire;
    logic        s1_advance;
    logic        s2_free;

    logic [5:0]  op;
    logic [5:0]  row;
    logic [31:0] imm_ext;

    assign i_cfg.ready = 1'b1;

    assign s2_free    = !r_s2_valid || o_out.ready;
    assign s1_advance = r_s1_valid && s2_free;
    assign i_in.ready = !r_s1_valid || s2_free;
    assign in_fire    = i_in.valid && i_in.ready;

    assign o_out.valid = r_s2_valid;
    assign o_out.data  = r_out;

    assign n_offset = i_in.data.last_word ? '0 : r_offset + 30'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg.valid) begin
            r_base <= i_cfg.data.base_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_offset <= n_offset;
            end
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_word <= i_in.data.instr_word;
            r_addr <= r_base + {r_offset, 2'b00};
        end
    end

    assign op = r_word[31:26];

    always_comb begin
        n_out = '0;
        row   = ROW_UNKNOWN;
        if (r_word == '0) begin
            row = ROW_NOOP;
        end else if (op == OP_SPECIAL) begin
            n_out.src_reg       = r_word[25:21];
            n_out.tgt_reg       = r_word[20:16];
            n_out.dst_reg       = r_word[15:11];
            n_out.shift_amount  = r_word[10:6];
            n_out.function_code = r_word[5:0];
            row                 = f_special_row(r_word[5:0]);
        end else if (op == OP_REGIMM) begin
            n_out.src_reg   = r_word[25:21];
            n_out.tgt_reg   = r_word[20:16];
            n_out.immediate = r_word[15:0];
            row             = f_regimm_row(r_word[20:16]);
        end else begin
            row = f_opcode_row(op);
            if (row != ROW_UNKNOWN) begin
                if (f_row_format(row) == FMT_J) begin
                    n_out.jump_field = r_word[25:0];
                end else begin
                    n_out.src_reg   = r_word[25:21];
                    n_out.tgt_reg   = r_word[20:16];
                    n_out.immediate = r_word[15:0];
                end
            end
        end
        imm_ext             = {{14{n_out.immediate[15]}}, n_out.immediate, 2'b00};
        n_out.code_index    = row;
        n_out.insn_format   = f_row_format(row);
        n_out.word_address  = r_addr;
        n_out.branch_target = {1'b0, r_addr[30:0]} + imm_ext + 32'd4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out <= n_out;
        end
    end

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.data.last_word) |=> (r_offset == '0))
        else $error("offset not restarted after last item");

    a_offset_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !i_in.data.last_word) |=> (r_offset == $past(r_offset) + 30'd1))
        else $error("offset did not advance");

    a_addr_carried: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance |=> (r_s2_valid && (r_out.word_address == $past(r_addr))))
        else $error("address lost between stages");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_valid && !r_s2_valid))
        else $error("pipeline not empty after reset");

endmodule

>>> tb/tb_mips_instruction_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mips_instruction_decoder_top
// Self-checking bench for the MIPS instruction decoder. A local decode model
// predicts row, format, fields, word address and branch target for every
// accepted item. A checker compares each output item with the oldest
// prediction. Directed words, a random stream over several base addresses
// and a long output stall are run with random idling unless held steady.
// ----------------------------------------------------------------------------
module tb_mips_instruction_decoder_top;
    import mid_pkg::*;

    localparam int MATCH_ROWS = 62;

    localparam logic [5:0] OP_J      = 6'h02;
    localparam logic [5:0] OP_JAL    = 6'h03;
    localparam logic [5:0] OP_BEQ    = 6'h04;
    localparam logic [5:0] OP_ADDI   = 6'h08;
    localparam logic [5:0] OP_LUI    = 6'h0F;
    localparam logic [5:0] OP_UNUSED = 6'h13;
    localparam logic [5:0] OP_SW     = 6'h2B;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_BREAK   = 6'h0D;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_UNUSED  = 6'h3F;
    localparam logic [5:0] FN_MOVF    = 6'h01;

    localparam logic [4:0] RT_BLTZ   = 5'h00;
    localparam logic [4:0] RT_BGEZ   = 5'h01;
    localparam logic [4:0] RT_BLTZAL = 5'h10;
    localparam logic [4:0] RT_BGEZAL = 5'h11;
    localparam logic [4:0] RT_UNUSED = 5'h1F;

    // mnemonic table: opcode, match key (funct or rt), format
    localparam logic [5:0] ROW_OPC [MATCH_ROWS] = '{
        6'h00, 6'h00, 6'h08, 6'h09, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h0C, 6'h00, 6'h0D, 6'h00, 6'h0E,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h0F, 6'h20, 6'h24,
        6'h21, 6'h25, 6'h23, 6'h22, 6'h26, 6'h28, 6'h29, 6'h2B, 6'h2D, 6'h2E,
        6'h04, 6'h05, 6'h01, 6'h07, 6'h01, 6'h06, 6'h01, 6'h01, 6'h00, 6'h00,
        6'h0A, 6'h0B, 6'h02, 6'h00, 6'h03, 6'h00, 6'h12, 6'h2A, 6'h32, 6'h3A,
        6'h00, 6'h00
    };
    localparam logic [5:0] ROW_KEY [MATCH_ROWS] = '{
        6'h20, 6'h21, 6'h00, 6'h00, 6'h22, 6'h23, 6'h18, 6'h19, 6'h1A, 6'h1B,
        6'h11, 6'h13, 6'h10, 6'h12, 6'h24, 6'h00, 6'h25, 6'h00, 6'h26, 6'h00,
        6'h27, 6'h00, 6'h04, 6'h02, 6'h06, 6'h03, 6'h07, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h01, 6'h00, 6'h11, 6'h00, 6'h00, 6'h10, 6'h2A, 6'h2B,
        6'h00, 6'h00, 6'h00, 6'h08, 6'h00, 6'h09, 6'h00, 6'h00, 6'h00, 6'h00,
        6'h0C, 6'h0D
    };
    localparam logic [1:0] ROW_FMT [MATCH_ROWS] = '{
        FMT_R, FMT_R, FMT_I, FMT_I, FMT_R, FMT_R, FMT_R, FMT_R, FMT_R, FMT_R,
        FMT_R, FMT_R, FMT_R, FMT_R, FMT_R, FMT_I, FMT_R, FMT_I, FMT_R, FMT_I,
        FMT_R, FMT_R, FMT_R, FMT_R, FMT_R, FMT_R, FMT_R, FMT_I, FMT_I, FMT_I,
        FMT_I, FMT_I, FMT_I, FMT_I, FMT_I, FMT_I, FMT_I, FMT_I, FMT_I, FMT_I,
        FMT_I, FMT_I, FMT_I, FMT_I, FMT_I, FMT_I, FMT_I, FMT_I, FMT_R, FMT_R,
        FMT_I, FMT_I, FMT_J, FMT_R, FMT_J, FMT_R, FMT_I, FMT_I, FMT_I, FMT_I,
        FMT_R, FMT_R
    };

    logic i_clk;
    logic i_rst_n;

    mid_stream_if #(.T(t_cfg_item)) cfg_if ();
    mid_stream_if #(.T(t_in_item))  in_if ();
    mid_stream_if #(.T(t_out_item)) out_if ();

    mips_instruction_decoder_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_out_item   expected_decodes [$];
    logic [31:0] model_base;
    logic [29:0] model_offset;
    int          err_count;
    int          rx_hold_cycles;
    bit          rx_steady;
    bit          tx_steady;
    t_out_item   got_item;
    t_out_item   want_item;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [31:0] mk_r(input logic [4:0] rs, input logic [4:0] rt,
                                         input logic [4:0] rd, input logic [4:0] sh,
                                         input logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] mk_i(input logic [5:0] op, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] mk_j(input logic [5:0] op, input logic [25:0] tgt);
        return {op, tgt};
    endfunction

    // decode one word against the table and advance the word offset
    task automatic predict_decode(input logic [31:0] w, input logic last);
        t_out_item   r;
        logic [5:0]  op;
        logic [31:0] imm_ext;
        bit          found;
        op    = w[31:26];
        r     = '0;
        found = 1'b0;
        r.code_index  = ROW_UNKNOWN;
        if (w == 32'd0) begin
            r.code_index = ROW_NOOP;
        end else if (op == OP_SPECIAL) begin
            r.src_reg       = w[25:21];
            r.tgt_reg       = w[20:16];
            r.dst_reg       = w[15:11];
            r.shift_amount  = w[10:6];
            r.function_code = w[5:0];
            for (int k = 0; k < MATCH_ROWS && !found; k++) begin
                if (ROW_OPC[k] == OP_SPECIAL && ROW_KEY[k] == w[5:0]) begin
                    r.code_index = 6'(k);
                    found        = 1'b1;
                end
            end
        end else begin
            for (int k = 0; k < MATCH_ROWS && !found; k++) begin
                if (ROW_OPC[k] == op) begin
                    if (ROW_FMT[k] == FMT_J) begin
                        r.jump_field = w[25:0];
                        r.code_index = 6'(k);
                        found        = 1'b1;
                    end else begin
                        r.src_reg   = w[25:21];
                        r.tgt_reg   = w[20:16];
                        r.immediate = w[15:0];
                        if (op != OP_REGIMM || ROW_KEY[k] == {1'b0, w[20:16]}) begin
                            r.code_index = 6'(k);
                            found        = 1'b1;
                        end
                    end
                end
            end
        end
        r.insn_format  = found ? ROW_FMT[r.code_index] : FMT_NONE;
        r.word_address = model_base + {model_offset, 2'b00};
        imm_ext        = {{16{r.immediate[15]}}, r.immediate};
        r.branch_target = (r.word_address & 32'h7FFF_FFFF) + (imm_ext << 2) + 32'd4;
        expected_decodes.push_back(r);
        model_offset = last ? 30'd0 : model_offset + 30'd1;
    endtask

    task automatic send_word(input logic [31:0] w, input logic last);
        if (!tx_steady && $urandom_range(99) < 17) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.data  <= '{instr_word: w, last_word: last};
        do @(posedge i_clk); while (!in_if.ready);
        predict_decode(w, last);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_decodes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] addr);
        wait_idle();
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{base_address: addr};
        do @(posedge i_clk); while (!cfg_if.ready);
        model_base = addr;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        int          sel;
        int          k;
        w   = $urandom;
        sel = $urandom_range(99);
        k   = $urandom_range(MATCH_ROWS - 1);
        if (sel < 75) begin
            if (ROW_OPC[k] == OP_SPECIAL)
                w = mk_r(w[25:21], w[20:16], w[15:11], w[10:6], ROW_KEY[k]);
            else if (ROW_OPC[k] == OP_REGIMM)
                w = mk_i(OP_REGIMM, w[25:21], ROW_KEY[k][4:0], w[15:0]);
            else
                w[31:26] = ROW_OPC[k];
        end else if (sel < 87) begin
            w[31:26] = w[26] ? OP_REGIMM : OP_SPECIAL;
        end else if (sel < 89) begin
            w = 32'd0;
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got_item = out_if.data;
            if (expected_decodes.size() == 0) begin
                report_mismatch("unexpected item, word_address", got_item.word_address, '0);
            end else begin
                want_item = expected_decodes.pop_front();
                check_field("code_index", 32'(got_item.code_index),
                            32'(want_item.code_index));
                check_field("insn_format", 32'(got_item.insn_format),
                            32'(want_item.insn_format));
                check_field("src_reg", 32'(got_item.src_reg), 32'(want_item.src_reg));
                check_field("tgt_reg", 32'(got_item.tgt_reg), 32'(want_item.tgt_reg));
                check_field("dst_reg", 32'(got_item.dst_reg), 32'(want_item.dst_reg));
                check_field("shift_amount", 32'(got_item.shift_amount),
                            32'(want_item.shift_amount));
                check_field("function_code", 32'(got_item.function_code),
                            32'(want_item.function_code));
                check_field("immediate", 32'(got_item.immediate),
                            32'(want_item.immediate));
                check_field("jump_field", 32'(got_item.jump_field),
                            32'(want_item.jump_field));
                check_field("word_address", got_item.word_address, want_item.word_address);
                check_field("branch_target", got_item.branch_target,
                            want_item.branch_target);
            end
        end
    end

    // output side: random stalls, or a counted hold-off
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            out_if.ready <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else begin
            out_if.ready <= rx_steady || ($urandom_range(99) >= 17);
        end
    end

    task automatic test_directed();
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(mk_r(5'd31, 5'd31, 5'd31, 5'd31, FN_SLL), 1'b0);
        send_word(mk_r(5'd1, 5'd2, 5'd3, 5'd0, FN_ADD), 1'b0);
        send_word(mk_r(5'd31, 5'd0, 5'd31, 5'd0, FN_UNUSED), 1'b0);
        send_word(mk_r(5'd0, 5'd0, 5'd0, 5'd0, FN_MOVF), 1'b0);
        send_word(mk_r(5'd31, 5'd0, 5'd0, 5'd0, FN_JR), 1'b0);
        send_word(mk_r(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL), 1'b1);
        send_word(mk_r(5'd0, 5'd0, 5'd0, 5'd0, FN_BREAK), 1'b0);
        send_word(mk_i(OP_REGIMM, 5'd5, RT_BLTZ, 16'h8000), 1'b0);
        send_word(mk_i(OP_REGIMM, 5'd5, RT_BGEZ, 16'h7FFF), 1'b0);
        write_base(32'hFFFF_FFF0);
        send_word(mk_i(OP_REGIMM, 5'd5, RT_BLTZAL, 16'hFFFF), 1'b0);
        send_word(mk_i(OP_REGIMM, 5'd5, RT_BGEZAL, 16'h0001), 1'b0);
        send_word(mk_i(OP_REGIMM, 5'd31, RT_UNUSED, 16'h1234), 1'b0);
        send_word(mk_j(OP_J, 26'h3FF_FFFF), 1'b0);
        send_word(mk_j(OP_JAL, 26'h000_0000), 1'b0);
        send_word(mk_i(OP_ADDI, 5'd31, 5'd31, 16'h8000), 1'b0);
        send_word(mk_i(OP_LUI, 5'd0, 5'd7, 16'hFFFF), 1'b0);
        send_word(mk_i(OP_BEQ, 5'd3, 5'd4, 16'hFFFE), 1'b0);
        send_word(mk_i(OP_SW, 5'd29, 5'd31, 16'h0004), 1'b0);
        send_word(mk_i(OP_UNUSED, 5'd31, 5'd31, 16'hFFFF), 1'b0);
        send_word(32'h8000_0000, 1'b1);
    endtask

    task automatic test_random_stream();
        logic [31:0] bases [6];
        bases = '{32'h0000_0000, 32'hFFFF_FFFC, $urandom, 32'h8000_0000,
                  32'h7FFF_FFF8, $urandom};
        for (int p = 0; p < 6; p++) begin
            write_base(bases[p]);
            tx_steady = (p == 2);
            rx_steady = (p == 2);
            repeat (100) send_word(rand_word(), $urandom_range(15) == 0);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_output_stall();
        wait_idle();
        rx_hold_cycles = 60;
        tx_steady      = 1'b1;
        repeat (40) send_word(rand_word(), $urandom_range(15) == 0);
        tx_steady = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        out_if.ready   = 1'b0;
        model_base     = '0;
        model_offset   = '0;
        err_count      = 0;
        rx_hold_cycles = 0;
        rx_steady      = 1'b0;
        tx_steady      = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_stream();
        test_output_stall();

        wait_idle();
        repeat (6) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/mid_pkg.sv
src/mid_stream_if.sv
src/mips_instruction_decoder_top.sv
tb/tb_mips_instruction_decoder_top.sv
